// File: rtl/mrr_pkg.sv
// Shared constants, types and sequencer states for the Miller-Rabin round unit.
package mrr_pkg;

  localparam int NUM_BITS  = 31;
  localparam int BIT_IDX_W = $clog2(NUM_BITS);
  localparam int CNT_W     = $clog2(NUM_BITS + 1);

  typedef logic [NUM_BITS-1:0] word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SHIFT,
    ST_POW_SQ,
    ST_POW_SQ_WAIT,
    ST_POW_MUL,
    ST_POW_MUL_WAIT,
    ST_TEST,
    ST_LOOP_CHK,
    ST_LOOP_SQ,
    ST_LOOP_WAIT,
    ST_LOOP_EVAL,
    ST_DONE
  } state_t;

endpackage

// File: rtl/mrr_modmul.sv
// Bit-serial modular multiplier: prod = (x * y) mod m, one bit of y per cycle.
module mrr_modmul (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  mrr_pkg::word_t x,
  input  mrr_pkg::word_t y,
  input  mrr_pkg::word_t m,
  output logic           done,
  output mrr_pkg::word_t prod
);
  import mrr_pkg::*;

  logic                 active;
  logic [BIT_IDX_W-1:0] cnt;
  word_t                acc;
  word_t                ysh;
  word_t                xr;
  word_t                mr;

  logic [NUM_BITS+1:0]  sum;
  logic [NUM_BITS+1:0]  m1;
  logic [NUM_BITS+1:0]  m2;
  word_t                acc_next;

  // Double and add in one step; the sum stays below 3m, so pick among s, s-m, s-2m.
  always_comb begin
    m1  = {2'b00, mr};
    m2  = {1'b0, mr, 1'b0};
    sum = {1'b0, acc, 1'b0} + (ysh[NUM_BITS-1] ? {2'b00, xr} : '0);
    if (sum >= m2) begin
      acc_next = NUM_BITS'(sum - m2);
    end else if (sum >= m1) begin
      acc_next = NUM_BITS'(sum - m1);
    end else begin
      acc_next = NUM_BITS'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= active && (cnt == '0);
      if (start) begin
        active <= 1'b1;
      end else if (active && (cnt == '0)) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      ysh <= y;
      xr  <= x;
      mr  <= m;
      cnt <= BIT_IDX_W'(NUM_BITS - 1);
    end else if (active) begin
      acc <= acc_next;
      ysh <= {ysh[NUM_BITS-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

  assign prod = acc;

endmodule

// File: rtl/miller_rabin_round.sv
// Top level of the Miller-Rabin round unit: sequencer around a shared modular multiplier.
//
// Usage: drive candidate (n) and witness (a) with start high while busy is low;
// that edge takes the beat. busy stays high until the verdict is delivered.
// The verdict beat appears for exactly one cycle with done high:
//   probably_prime = 1 when a^q mod n is 1 or n-1, or a later square hits n-1
//   input_error    = 1 (and probably_prime = 0) when n < 3, a == 0 or a > n-2.
// The receiver cannot stall: done is a one-cycle pulse and must be sampled.
//
// Sequence: n-1 is split into 2^k * q by shifting one bit per cycle. Then a^q mod n
// is built left to right over all NUM_BITS exponent bits, and up to k-1 further
// squares follow. Every product uses the bit-serial multiplier, issued from its
// own state and awaited in a wait state; each square of the final loop adds a
// check and an evaluate state. There are P = NUM_BITS + popcount(q) + L products,
// L of them in the final loop. An input error goes from the check state straight
// to the verdict beat. The next beat is taken once the sequencer is back in idle,
// in the cycle after the verdict.
// Reset: rst (synchronous) returns the sequencer to idle and drops any beat in work.
module miller_rabin_round_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  mrr_pkg::word_t candidate,
  input  mrr_pkg::word_t witness,
  output logic           busy,
  output logic           done,
  output logic           probably_prime,
  output logic           input_error
);
  import mrr_pkg::*;

  state_t               state;
  state_t               state_next;

  word_t                n;
  word_t                a;
  word_t                nm1;
  word_t                q;
  word_t                r;
  logic [CNT_W-1:0]     k;
  logic [CNT_W-1:0]     i;
  logic [BIT_IDX_W-1:0] bidx;
  logic                 prime;
  logic                 err;

  logic                 bad_input;
  logic                 mul_start;
  logic                 mul_use_a;
  logic                 mul_done;
  word_t                mul_y;
  word_t                prod;

  // Witness must sit in 1..n-2; compare a+2 > n to avoid underflow.
  assign bad_input = (n < NUM_BITS'(3)) || (a == '0) ||
                     (({1'b0, a} + (NUM_BITS + 1)'(2)) > {1'b0, n});

  assign mul_y = mul_use_a ? a : r;

  mrr_modmul u_modmul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (r),
    .y     (mul_y),
    .m     (n),
    .done  (mul_done),
    .prod  (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:         if (start) state_next = ST_CHECK;
      ST_CHECK:        state_next = bad_input ? ST_DONE : ST_SHIFT;
      ST_SHIFT: begin
        if (q[0] || (k == CNT_W'(NUM_BITS))) state_next = ST_POW_SQ;
      end
      ST_POW_SQ:       state_next = ST_POW_SQ_WAIT;
      ST_POW_SQ_WAIT: begin
        if (mul_done) begin
          if (q[bidx])           state_next = ST_POW_MUL;
          else if (bidx == '0)   state_next = ST_TEST;
          else                   state_next = ST_POW_SQ;
        end
      end
      ST_POW_MUL:      state_next = ST_POW_MUL_WAIT;
      ST_POW_MUL_WAIT: begin
        if (mul_done) state_next = (bidx == '0) ? ST_TEST : ST_POW_SQ;
      end
      ST_TEST: begin
        state_next = ((r == NUM_BITS'(1)) || (r == nm1)) ? ST_DONE : ST_LOOP_CHK;
      end
      ST_LOOP_CHK:     state_next = (i < k) ? ST_LOOP_SQ : ST_DONE;
      ST_LOOP_SQ:      state_next = ST_LOOP_WAIT;
      ST_LOOP_WAIT:    if (mul_done) state_next = ST_LOOP_EVAL;
      ST_LOOP_EVAL: begin
        state_next = ((r == NUM_BITS'(1)) || (r == nm1)) ? ST_DONE : ST_LOOP_CHK;
      end
      ST_DONE:         state_next = ST_IDLE;
      default:         state_next = ST_IDLE;
    endcase
  end

  // Output and multiplier control.
  always_comb begin
    mul_start = 1'b0;
    mul_use_a = 1'b0;
    done      = 1'b0;
    unique case (state)
      ST_POW_SQ:  mul_start = 1'b1;
      ST_POW_MUL: begin
        mul_start = 1'b1;
        mul_use_a = 1'b1;
      end
      ST_POW_MUL_WAIT: mul_use_a = 1'b1;
      ST_LOOP_SQ: mul_start = 1'b1;
      ST_DONE:    done = 1'b1;
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  assign busy           = (state != ST_IDLE);
  assign probably_prime = prime;
  assign input_error    = err;

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      prime <= 1'b0;
      err   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            n <= candidate;
            a <= witness;
          end
        end
        ST_CHECK: begin
          err   <= bad_input;
          prime <= 1'b0;
          nm1   <= n - 1'b1;
          q     <= n - 1'b1;
          k     <= '0;
          r     <= NUM_BITS'(1);
          bidx  <= BIT_IDX_W'(NUM_BITS - 1);
        end
        ST_SHIFT: begin
          // Strip trailing zeros of n-1, one per cycle.
          if (!q[0] && (k != CNT_W'(NUM_BITS))) begin
            q <= {1'b0, q[NUM_BITS-1:1]};
            k <= k + 1'b1;
          end
        end
        ST_POW_SQ_WAIT: begin
          if (mul_done) begin
            r <= prod;
            if (!q[bidx] && (bidx != '0)) bidx <= bidx - 1'b1;
          end
        end
        ST_POW_MUL_WAIT: begin
          if (mul_done) begin
            r <= prod;
            if (bidx != '0) bidx <= bidx - 1'b1;
          end
        end
        ST_TEST: begin
          if ((r == NUM_BITS'(1)) || (r == nm1)) prime <= 1'b1;
          i <= CNT_W'(1);
        end
        ST_LOOP_WAIT: begin
          if (mul_done) begin
            r <= prod;
            i <= i + 1'b1;
          end
        end
        ST_LOOP_EVAL: begin
          if (r == nm1) prime <= 1'b1;
        end
        default: begin
          prime <= prime;
        end
      endcase
    end
  end

endmodule
